// File: src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, state and event codes, register map and reset values for the
// bed presence and alarm state machine.
// ----------------------------------------------------------------------------
package bpa_pkg;

	// APB register map
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;

	localparam logic [2:0] REG_WAKE_MOVE   = 3'd0;
	localparam logic [2:0] REG_STOP_HOLD   = 3'd1;
	localparam logic [2:0] REG_STILL       = 3'd2;
	localparam logic [2:0] REG_BREATH      = 3'd3;
	localparam logic [2:0] REG_RESLEEP     = 3'd4;
	localparam logic [2:0] REG_LEAVE       = 3'd5;
	localparam logic [2:0] REG_GUARD       = 3'd6;
	localparam logic [2:0] REG_SEAT        = 3'd7;

	// register reset values
	localparam logic [7:0]  RST_WAKE_MOVE = 8'd30;
	localparam logic [31:0] RST_STOP_HOLD = 32'd3000;
	localparam logic [7:0]  RST_STILL     = 8'd10;
	localparam logic [7:0]  RST_BREATH    = 8'd20;
	localparam logic [31:0] RST_RESLEEP   = 32'd180000;
	localparam logic [31:0] RST_LEAVE     = 32'd60000;
	localparam logic [31:0] RST_GUARD     = 32'd1200000;
	localparam logic [31:0] RST_SEAT      = 32'd5000;

	// machine states
	localparam logic [2:0] ST_AWAY    = 3'd0;
	localparam logic [2:0] ST_SEATED  = 3'd1;
	localparam logic [2:0] ST_SLEEP   = 3'd2;
	localparam logic [2:0] ST_RINGING = 3'd3;
	localparam logic [2:0] ST_GUARD   = 3'd4;

	// event codes
	localparam logic [2:0] EV_CHANGED = 3'd0;
	localparam logic [2:0] EV_STOP    = 3'd1;
	localparam logic [2:0] EV_WAKE    = 3'd2;
	localparam logic [2:0] EV_RESUME  = 3'd3;
	localparam logic [2:0] EV_SIT     = 3'd4;
	localparam logic [2:0] EV_AWAY    = 3'd5;

	// input commands
	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_SLEEP   = 2'd1;
	localparam logic [1:0] MODE_RINGING = 2'd2;
	localparam logic [1:0] MODE_AWAY    = 2'd3;

	// movement above this level counts as someone seated
	localparam logic [7:0] SEAT_MOVE_LEVEL = 8'd5;

	typedef struct packed {
		logic [7:0]  wake_move_threshold;
		logic [31:0] stop_hold_ms;
		logic [7:0]  still_threshold;
		logic [7:0]  sleep_breath_limit;
		logic [31:0] doze_hold_ms;
		logic [31:0] absent_hold_ms;
		logic [31:0] guard_span_ms;
		logic [31:0] sit_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        in_bed;
		logic        presence;
		logic [7:0]  motion;
		logic [7:0]  resp_rate;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [2:0]  cur;
		logic [31:0] enter_t;
		logic [31:0] move_t;
		logic [31:0] still_t;
		logic [31:0] leave_t;
		logic [31:0] seat_t;
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0] event_code;
		logic [2:0] new_state;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} evt_pair_t;

	// state entry: stamp entry time, drop all debounce timers
	function automatic ctrl_state_t enter_state(logic [2:0] target, logic [31:0] now);
		ctrl_state_t r;
		r = '0;
		r.cur = target;
		r.enter_t = now;
		return r;
	endfunction

	function automatic result_t mk_event(logic [2:0] code, logic [2:0] st, logic last);
		result_t r;
		r.event_code = code;
		r.new_state = st;
		r.last = last;
		return r;
	endfunction

endpackage

// File: src/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_in_if / bpa_out_if
// Valid/ready channels for radar status items and for result events.
// ----------------------------------------------------------------------------
interface bpa_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic        in_bed;
	logic        presence;
	logic [7:0]  motion;
	logic [7:0]  resp_rate;
	logic [31:0] now_ms;

	modport source (output valid, mode, in_bed, presence, motion, resp_rate, now_ms,
		input ready);
	modport sink (input valid, mode, in_bed, presence, motion, resp_rate, now_ms,
		output ready);
endinterface

interface bpa_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_code;
	logic [2:0] new_state;
	logic       last;

	modport source (output valid, event_code, new_state, last, input ready);
	modport sink (input valid, event_code, new_state, last, output ready);
endinterface

// File: src/bed_presence_alarm_fsm_unit.sv
// ----------------------------------------------------------------------------
// bed_presence_alarm_fsm_unit
// Occupancy and alarm state machine driven by radar status items.
// ----------------------------------------------------------------------------
// Path: item_s1 register, then the two-entry result register; a stall on out_ch
//   can hold an item in item_s1. Throughput: one item per cycle when it yields
//   at most one event and out_ch is ready; the result register drains one event
//   per transfer, so an item with two events holds back the next until one is sent.
// Reset: arst_n clears the state to day away, all timers to idle, both
//   channels to empty and the registers to their defaults.
// ----------------------------------------------------------------------------
module bed_presence_alarm_fsm_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpa_pkg::PADDR_W-1:0]   paddr,
	input  logic [bpa_pkg::PDATA_W-1:0]   pwdata,
	output logic [bpa_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	bpa_in_if.sink                        in_ch,
	bpa_out_if.source                     out_ch
);
	import bpa_pkg::*;

	cfg_t        cfg;
	item_t       item_s1;
	logic        valid_s1;
	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	evt_pair_t   evts;
	logic        can_load;
	logic        go;
	logic        accept;

	assign go           = valid_s1 && can_load;
	assign in_ch.ready  = !valid_s1 || can_load;
	assign accept       = in_ch.valid && in_ch.ready;

	bpa_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.mode      <= in_ch.mode;
			item_s1.in_bed    <= in_ch.in_bed;
			item_s1.presence  <= in_ch.presence;
			item_s1.motion    <= in_ch.motion;
			item_s1.resp_rate <= in_ch.resp_rate;
			item_s1.now_ms    <= in_ch.now_ms;
		end
	end

	bpa_step u_step (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.evts (evts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (go) begin
			state_q <= state_nxt;
		end
	end

	bpa_evt_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go),
		.evts     (evts),
		.can_load (can_load),
		.out_ch   (out_ch)
	);

endmodule

// File: src/bpa_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpa_cfg_regs
// APB register file holding thresholds and debounce durations.
// ----------------------------------------------------------------------------
module bpa_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpa_pkg::PADDR_W-1:0]   paddr,
	input  logic [bpa_pkg::PDATA_W-1:0]   pwdata,
	output logic [bpa_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output bpa_pkg::cfg_t                 cfg
);
	import bpa_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[PADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wake_move_threshold <= RST_WAKE_MOVE;
			cfg_q.stop_hold_ms        <= RST_STOP_HOLD;
			cfg_q.still_threshold     <= RST_STILL;
			cfg_q.sleep_breath_limit  <= RST_BREATH;
			cfg_q.doze_hold_ms        <= RST_RESLEEP;
			cfg_q.absent_hold_ms      <= RST_LEAVE;
			cfg_q.guard_span_ms       <= RST_GUARD;
			cfg_q.sit_hold_ms         <= RST_SEAT;
		end else if (wr_en) begin
			unique case (idx)
				REG_WAKE_MOVE: cfg_q.wake_move_threshold <= pwdata[7:0];
				REG_STOP_HOLD: cfg_q.stop_hold_ms        <= pwdata;
				REG_STILL:     cfg_q.still_threshold     <= pwdata[7:0];
				REG_BREATH:    cfg_q.sleep_breath_limit  <= pwdata[7:0];
				REG_RESLEEP:   cfg_q.doze_hold_ms        <= pwdata;
				REG_LEAVE:     cfg_q.absent_hold_ms      <= pwdata;
				REG_GUARD:     cfg_q.guard_span_ms       <= pwdata;
				REG_SEAT:      cfg_q.sit_hold_ms         <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WAKE_MOVE: prdata = {24'd0, cfg_q.wake_move_threshold};
			REG_STOP_HOLD: prdata = cfg_q.stop_hold_ms;
			REG_STILL:     prdata = {24'd0, cfg_q.still_threshold};
			REG_BREATH:    prdata = {24'd0, cfg_q.sleep_breath_limit};
			REG_RESLEEP:   prdata = cfg_q.doze_hold_ms;
			REG_LEAVE:     prdata = cfg_q.absent_hold_ms;
			REG_GUARD:     prdata = cfg_q.guard_span_ms;
			REG_SEAT:      prdata = cfg_q.sit_hold_ms;
			default:       prdata = '0;
		endcase
	end

endmodule

// File: src/bpa_step.sv
// ----------------------------------------------------------------------------
// bpa_step
// Next-state and event logic for one status item: one shared debounce timer
// compare and one guard period compare.
// ----------------------------------------------------------------------------
module bpa_step (
	input  bpa_pkg::item_t       item,
	input  bpa_pkg::ctrl_state_t st,
	input  bpa_pkg::cfg_t        cfg,
	output bpa_pkg::ctrl_state_t nxt,
	output bpa_pkg::evt_pair_t   evts
);
	import bpa_pkg::*;

	logic        present;
	logic        sleepy;
	logic        occupied;
	logic        is_seated;
	logic [31:0] raw_stamp;
	logic [31:0] stamp;
	logic [31:0] limit;
	logic [31:0] elapsed;
	logic [31:0] guard_elapsed;
	logic        a_done;
	logic        guard_done;
	logic [2:0]  target;
	logic [2:0]  day_target;

	assign present    = item.in_bed && item.presence;
	assign sleepy     = (item.motion < cfg.still_threshold) && (item.resp_rate != 8'd0)
		&& (item.resp_rate <= cfg.sleep_breath_limit);
	assign occupied   = (item.motion > SEAT_MOVE_LEVEL) || item.presence;
	assign is_seated  = (st.cur == ST_SEATED);
	assign day_target = occupied ? ST_SEATED : ST_AWAY;

	// pick the one debounce timer that matters in this state
	always_comb begin
		raw_stamp = '0;
		limit     = '0;
		unique case (st.cur) inside
			ST_RINGING: begin
				raw_stamp = st.move_t;
				limit     = cfg.stop_hold_ms;
			end
			ST_GUARD: begin
				raw_stamp = present ? st.still_t : st.leave_t;
				limit     = present ? cfg.doze_hold_ms : cfg.absent_hold_ms;
			end
			ST_AWAY, ST_SEATED: begin
				raw_stamp = st.seat_t;
				limit     = cfg.sit_hold_ms;
			end
			default: ;
		endcase
	end

	// a zero stamp is idle: start the timer now
	assign stamp         = (raw_stamp == 32'd0) ? item.now_ms : raw_stamp;
	assign elapsed       = item.now_ms - stamp;
	assign a_done        = (elapsed >= limit);
	assign guard_elapsed = item.now_ms - st.enter_t;
	assign guard_done    = (guard_elapsed >= cfg.guard_span_ms);

	always_comb begin
		nxt         = st;
		evts        = '0;
		target      = ST_AWAY;
		unique case (item.mode)
			MODE_SLEEP:   target = ST_SLEEP;
			MODE_RINGING: target = ST_RINGING;
			MODE_AWAY:    target = ST_AWAY;
			default:      target = ST_AWAY;
		endcase

		if (item.mode != MODE_TICK) begin
			if (target != st.cur) begin
				nxt        = enter_state(target, item.now_ms);
				evts.count = 2'd1;
				evts.first = mk_event(EV_CHANGED, target, 1'b1);
			end
		end else begin
			unique case (st.cur) inside
				ST_RINGING: begin
					if (!present) begin
						nxt         = enter_state(ST_GUARD, item.now_ms);
						nxt.leave_t = item.now_ms;
						evts.count  = 2'd2;
						evts.first  = mk_event(EV_STOP, ST_AWAY, 1'b0);
						evts.second = mk_event(EV_CHANGED, ST_GUARD, 1'b1);
					end else if (item.motion >= cfg.wake_move_threshold) begin
						if (a_done) begin
							nxt         = enter_state(ST_GUARD, item.now_ms);
							evts.count  = 2'd2;
							evts.first  = mk_event(EV_STOP, ST_AWAY, 1'b0);
							evts.second = mk_event(EV_CHANGED, ST_GUARD, 1'b1);
						end else begin
							nxt.move_t = stamp;
						end
					end else begin
						nxt.move_t = '0;
					end
				end
				ST_GUARD: begin
					if (!present) begin
						nxt.still_t = '0;
						if (a_done) begin
							nxt         = enter_state(ST_AWAY, item.now_ms);
							evts.count  = 2'd2;
							evts.first  = mk_event(EV_WAKE, ST_AWAY, 1'b0);
							evts.second = mk_event(EV_CHANGED, ST_AWAY, 1'b1);
						end else begin
							nxt.leave_t = stamp;
						end
					end else begin
						nxt.leave_t = '0;
						if (sleepy && a_done) begin
							nxt         = enter_state(ST_RINGING, item.now_ms);
							evts.count  = 2'd2;
							evts.first  = mk_event(EV_RESUME, ST_AWAY, 1'b0);
							evts.second = mk_event(EV_CHANGED, ST_RINGING, 1'b1);
						end else begin
							nxt.still_t = sleepy ? stamp : 32'd0;
							if (guard_done) begin
								nxt         = enter_state(ST_AWAY, item.now_ms);
								evts.count  = 2'd2;
								evts.first  = mk_event(EV_WAKE, ST_AWAY, 1'b0);
								evts.second = mk_event(EV_CHANGED, ST_AWAY, 1'b1);
							end
						end
					end
				end
				ST_AWAY, ST_SEATED: begin
					if (occupied != is_seated) begin
						if (a_done) begin
							nxt         = enter_state(day_target, item.now_ms);
							evts.count  = 2'd2;
							evts.first  = mk_event(EV_CHANGED, day_target, 1'b0);
							evts.second = mk_event(occupied ? EV_SIT : EV_AWAY,
								ST_AWAY, 1'b1);
						end else begin
							nxt.seat_t = stamp;
						end
					end else begin
						nxt.seat_t = '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: src/bpa_evt_buf.sv
// ----------------------------------------------------------------------------
// bpa_evt_buf
// Two-entry result register: loads the events of one item and presents them
// one per transfer.
// ----------------------------------------------------------------------------
module bpa_evt_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  bpa_pkg::evt_pair_t evts,
	output logic               can_load,
	bpa_out_if.source          out_ch
);
	import bpa_pkg::*;

	logic [1:0] cnt_q;
	result_t    head_q;
	result_t    tail_q;
	logic       pop;

	assign pop      = out_ch.valid && out_ch.ready;
	assign can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ch.ready);

	assign out_ch.valid      = (cnt_q != 2'd0);
	assign out_ch.event_code = head_q.event_code;
	assign out_ch.new_state  = head_q.new_state;
	assign out_ch.last       = head_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= evts.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= evts.first;
			tail_q <= evts.second;
		end else if (pop) begin
			// advance the second event to the head
			head_q <= tail_q;
		end
	end

endmodule

// File: src/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] event_code,
	input logic [2:0] new_state,
	input logic       last
);
	import bpa_pkg::*;

	// hold a pending event until transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// an event that is not last is followed at once by its partner
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("second event of a pair missing");

	// only state changed events carry a state
	a_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_code != EV_CHANGED) |-> (new_state == ST_AWAY))
		else $error("state field set on a non state-change event");

	// the first edge after reset shows no result
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind bed_presence_alarm_fsm_unit bpa_checker u_bpa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.event_code (out_ch.event_code),
	.new_state  (out_ch.new_state),
	.last       (out_ch.last)
);
